/* design/brb_pkg.sv */
// Package for the byte ring buffer: field widths, function and status codes,
// and the command record passed from the front end to the back end.
// Depends on nothing.
package brb_pkg;

   localparam int FUNC_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 11;

   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DISCARD = 3'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_DATA  = 2'd2;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_READ,
      OP_PEEK,
      OP_DISCARD,
      OP_STATUS
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data_byte;
      logic [COUNT_W-1:0]  count;
      logic                burst_end;
      logic                zero_count;
      logic                oversize;
   } cmd_type;

endpackage

/* design/brb_if.sv */
// Handshake channels of the byte ring buffer: request and response.
// Depends on brb_pkg for the field widths.
interface brb_req_if import brb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [BYTE_W-1:0]   data_byte;
   logic [COUNT_W-1:0]  count;
   logic                burst_end;

   modport source (output valid, func, data_byte, count, burst_end, input ready);
   modport sink (input valid, func, data_byte, count, burst_end, output ready);
endinterface

interface brb_rsp_if import brb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic [STATUS_W-1:0] status;
   logic [FILL_W-1:0]   fill_count;
   logic                is_empty;
   logic                is_full;
   logic                last;

   modport source (output valid, out_byte, status, fill_count, is_empty, is_full, last,
                   input ready);
   modport sink (input valid, out_byte, status, fill_count, is_empty, is_full, last,
                 output ready);
endinterface

/* design/brb_front.sv */
// Front end of the byte ring buffer: takes request beats, decodes them into
// commands and hands them to the command queue. Depends on brb_pkg, brb_if.
module brb_front import brb_pkg::*; #(
   parameter int MAX_BURST = 64
) (
   input  logic         clock,
   input  logic         reset,
   brb_req_if.sink      req_ch,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output cmd_type      cmd
);

   logic    valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   assign req_ch.ready = !valid_ff || cmd_ready;
   assign cmd_valid    = valid_ff;
   assign cmd          = cmd_ff;

   always_comb begin
      case (req_ch.func)
         FUNC_WRITE:   cmd_in.op = OP_WRITE;
         FUNC_READ:    cmd_in.op = OP_READ;
         FUNC_PEEK:    cmd_in.op = OP_PEEK;
         FUNC_DISCARD: cmd_in.op = OP_DISCARD;
         default:      cmd_in.op = OP_STATUS;
      endcase
      cmd_in.data_byte  = req_ch.data_byte;
      cmd_in.count      = req_ch.count;
      cmd_in.burst_end  = req_ch.burst_end;
      cmd_in.zero_count = (req_ch.count == '0);
      cmd_in.oversize   = (req_ch.count > COUNT_W'(MAX_BURST));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

/* design/brb_queue.sv */
// Short command queue between the front end and the back end of the byte
// ring buffer. Depends on brb_pkg.
module brb_queue import brb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW:0]   wr_ptr_ff;
   logic [QUEUE_AW:0]   rd_ptr_ff;
   logic                push;
   logic                pop;

   assign push_ready = !((wr_ptr_ff[QUEUE_AW] != rd_ptr_ff[QUEUE_AW]) &&
                         (wr_ptr_ff[QUEUE_AW-1:0] == rd_ptr_ff[QUEUE_AW-1:0]));
   assign pop_valid  = (wr_ptr_ff != rd_ptr_ff);
   assign pop_cmd    = entry_ff[rd_ptr_ff[QUEUE_AW-1:0]];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff[QUEUE_AW-1:0]] <= push_cmd;
      end
   end

endmodule

/* design/brb_back.sv */
// Back end of the byte ring buffer: byte store, pointers, burst state and the
// response register. Depends on brb_pkg and brb_if.
module brb_back import brb_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   output logic      cmd_ready,
   input  cmd_type   cmd,
   brb_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = AW + 1;
   localparam int XW = (PW > COUNT_W) ? PW : COUNT_W;
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

   typedef enum logic {
      BK_CMD,
      BK_FETCH
   } back_state_type;

   logic [BYTE_W-1:0]   store_ff [DEPTH];
   logic [BYTE_W-1:0]   rd_byte_ff;

   back_state_type      state_ff, state_in;
   logic [PW-1:0]       rp_ff, rp_in;
   logic [PW-1:0]       wp_ff, wp_in;
   logic [COUNT_W-1:0]  boff_ff, boff_in;
   logic [COUNT_W-1:0]  blen_ff, blen_in;
   logic                bact_ff, bact_in;
   logic                brej_ff, brej_in;
   logic [AW-1:0]       faddr_ff, faddr_in;
   logic [COUNT_W-1:0]  left_ff, left_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_full_ff, rsp_full_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_mem_ff, rsp_mem_in;

   logic                load;
   logic                emit;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [PW-1:0]       fill_now;
   logic [PW-1:0]       free_now;
   logic [PW-1:0]       fill_next;
   logic [XW-1:0]       count_x;
   logic                lack_data;
   logic                lack_space;
   logic [COUNT_W-1:0]  off;
   logic [COUNT_W-1:0]  len;
   logic [STATUS_W-1:0] r_status;
   logic                r_last;
   logic                r_mem;

   assign load      = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_ready = load && (state_ff == BK_CMD);
   assign emit      = load && ((state_ff == BK_FETCH) || cmd_valid);
   assign rd_en     = emit && r_mem;

   assign fill_now   = wp_ff - rp_ff;
   assign free_now   = DEPTH_P - fill_now;
   assign count_x    = XW'(cmd.count);
   assign lack_data  = cmd.oversize || (count_x > XW'(fill_now));
   assign lack_space = cmd.oversize || (count_x > XW'(free_now));
   assign fill_next  = wp_in - rp_in;

   always_comb begin
      state_in = state_ff;
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      boff_in  = boff_ff;
      blen_in  = blen_ff;
      bact_in  = bact_ff;
      brej_in  = brej_ff;
      faddr_in = faddr_ff;
      left_in  = left_ff;
      r_status = ST_OK;
      r_last   = 1'b1;
      r_mem    = 1'b0;
      rd_addr  = faddr_ff;
      wr_en    = 1'b0;
      wr_addr  = wp_ff[AW-1:0];
      off      = boff_ff;
      len      = blen_ff;

      if (state_ff == BK_FETCH) begin
         if (load) begin
            r_mem    = 1'b1;
            faddr_in = faddr_ff + 1'b1;
            left_in  = left_ff - 1'b1;
            r_last   = (left_ff == COUNT_W'(1));
            if (left_ff == COUNT_W'(1)) begin
               state_in = BK_CMD;
            end
         end
      end else if (cmd_valid && load) begin
         case (cmd.op)
            OP_WRITE: begin
               if (!bact_ff && !brej_ff && cmd.zero_count) begin
                  r_status = ST_OK;
               end else if (!bact_ff && !brej_ff && lack_space) begin
                  r_status = ST_NO_SPACE;
                  brej_in  = !cmd.burst_end;
               end else if (brej_ff) begin
                  r_status = ST_NO_SPACE;
                  if (cmd.burst_end) begin
                     brej_in = 1'b0;
                  end
               end else begin
                  off = bact_ff ? boff_ff : '0;
                  len = bact_ff ? blen_ff : cmd.count;
                  if (off < len) begin
                     wr_en   = 1'b1;
                     wr_addr = wp_ff[AW-1:0] + AW'(off);
                     off     = off + 1'b1;
                  end
                  if (cmd.burst_end) begin
                     wp_in   = wp_ff + PW'(off);
                     bact_in = 1'b0;
                     boff_in = '0;
                     blen_in = '0;
                  end else begin
                     bact_in = 1'b1;
                     boff_in = off;
                     blen_in = len;
                  end
               end
            end
            OP_READ, OP_PEEK: begin
               if (cmd.zero_count) begin
                  r_status = ST_OK;
               end else if (lack_data) begin
                  r_status = ST_NO_DATA;
               end else begin
                  r_mem    = 1'b1;
                  rd_addr  = rp_ff[AW-1:0];
                  faddr_in = rp_ff[AW-1:0] + 1'b1;
                  if (cmd.op == OP_READ) begin
                     rp_in = rp_ff + PW'(cmd.count);
                  end
                  if (cmd.count != COUNT_W'(1)) begin
                     r_last   = 1'b0;
                     left_in  = cmd.count - 1'b1;
                     state_in = BK_FETCH;
                  end
               end
            end
            OP_DISCARD: begin
               if (lack_data) begin
                  r_status = ST_NO_DATA;
               end else begin
                  rp_in = rp_ff + PW'(cmd.count);
               end
            end
            default: begin
               r_status = ST_OK;
            end
         endcase
      end

      rsp_valid_in  = load ? emit : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_mem_in    = rsp_mem_ff;
      if (emit) begin
         rsp_status_in = r_status;
         rsp_fill_in   = FILL_W'(fill_next);
         rsp_empty_in  = (fill_next == '0);
         rsp_full_in   = (fill_next == DEPTH_P);
         rsp_last_in   = r_last;
         rsp_mem_in    = r_mem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CMD;
         rp_ff         <= '0;
         wp_ff         <= '0;
         boff_ff       <= '0;
         blen_ff       <= '0;
         bact_ff       <= 1'b0;
         brej_ff       <= 1'b0;
         faddr_ff      <= '0;
         left_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_fill_ff   <= '0;
         rsp_empty_ff  <= 1'b1;
         rsp_full_ff   <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_mem_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         boff_ff       <= boff_in;
         blen_ff       <= blen_in;
         bact_ff       <= bact_in;
         brej_ff       <= brej_in;
         faddr_ff      <= faddr_in;
         left_ff       <= left_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_mem_ff    <= rsp_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= cmd.data_byte;
      end
      if (rd_en) begin
         rd_byte_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = rsp_mem_ff ? rd_byte_ff : '0;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.fill_count = rsp_fill_ff;
   assign rsp_ch.is_empty   = rsp_empty_ff;
   assign rsp_ch.is_full    = rsp_full_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

/* design/byte_ring_buffer.sv */
// Byte ring buffer of DEPTH entries with wrap-bit read and write pointers.
// Top level: front end, command queue and back end. Depends on brb_pkg,
// brb_if, brb_front, brb_queue and brb_back.
//
// Requests arrive as beats on req_ch: write bytes of a burst, read, peek,
// discard or status. Each request gives one response beat on rsp_ch, except a
// successful read or peek of N bytes, which gives N beats, oldest byte first,
// with last set on the final one. Every response carries the fill level,
// empty and full after the whole operation.
// The front end registers and decodes one request beat per cycle while the
// queue has room, and feeds a four-entry command queue. When rsp_ch does not
// stall, the back end executes one command per cycle; a read or peek of N
// bytes holds it until its last byte, one byte per cycle from the single read
// port of the byte store. A request passes the front, queue and response registers.
// Reset clears the pointers and burst state; the store is not cleared and
// needs no sweep, so requests are taken as soon as reset is released.
// When rsp_ch stalls, the response register holds its beat, the back end
// waits, the queue fills and req_ch.ready then drops.
module byte_ring_buffer import brb_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic      clock,
   input  logic      reset,
   brb_req_if.sink   req_ch,
   brb_rsp_if.source rsp_ch
);

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    back_valid;
   logic    back_ready;
   cmd_type back_cmd;

   brb_front #(
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   brb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   brb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* verif/byte_ring_buffer_tb.sv */
// Self-checking testbench for byte_ring_buffer: a directed table of request beats,
// then random write bursts, reads, peeks, discards and status requests, with random
// stalls on both channels. Depends on brb_pkg, brb_if and the byte_ring_buffer RTL.
module byte_ring_buffer_tb;
   import brb_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int AW          = $clog2(DEPTH);
   localparam int MAX_BURST   = 64;
   localparam int ITEMS       = 110;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = 20;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   typedef struct {
      logic [BYTE_W-1:0]   out_byte;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill_count;
      logic                is_empty;
      logic                is_full;
      logic                last;
   } rsp_beat_type;

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [BYTE_W-1:0]   data_byte;
      logic [COUNT_W-1:0]  count;
      logic                burst_end;
      bit                  typed;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill_count;
   } script_row_type;

   // The typed rows answer one beat each; the others are left to the predictor.
   script_row_type script [25] = '{
      '{OP_STATUS,      8'h00, 7'd0,   1'b0, 1'b1, ST_OK,       11'd0},
      '{OP_READ,        8'h00, 7'd1,   1'b0, 1'b1, ST_NO_DATA,  11'd0},
      '{OP_PEEK,        8'h00, 7'd0,   1'b0, 1'b1, ST_OK,       11'd0},
      '{OP_DISCARD,     8'h00, 7'd5,   1'b0, 1'b1, ST_NO_DATA,  11'd0},
      '{OP_WRITE,       8'hFF, 7'd65,  1'b1, 1'b1, ST_NO_SPACE, 11'd0},
      '{OP_WRITE,       8'h5A, 7'd0,   1'b0, 1'b1, ST_OK,       11'd0},
      '{OP_WRITE,       8'h00, 7'd3,   1'b0, 1'b1, ST_OK,       11'd0},
      '{OP_WRITE,       8'hFF, 7'd0,   1'b0, 1'b1, ST_OK,       11'd0},
      '{OP_WRITE,       8'hA5, 7'd0,   1'b1, 1'b1, ST_OK,       11'd3},
      '{OP_WRITE,       8'h11, 7'd4,   1'b0, 1'b1, ST_OK,       11'd3},
      '{FUNC_UNUSED_LO, 8'h00, 7'd0,   1'b0, 1'b1, ST_OK,       11'd3},
      '{OP_WRITE,       8'h22, 7'd127, 1'b1, 1'b1, ST_OK,       11'd5},
      '{OP_WRITE,       8'h44, 7'd2,   1'b0, 1'b1, ST_OK,       11'd5},
      '{OP_WRITE,       8'h55, 7'd0,   1'b0, 1'b1, ST_OK,       11'd5},
      '{OP_WRITE,       8'h66, 7'd0,   1'b1, 1'b1, ST_OK,       11'd7},
      '{OP_PEEK,        8'h00, 7'd3,   1'b0, 1'b0, ST_OK,       11'd0},
      '{OP_READ,        8'h00, 7'd65,  1'b0, 1'b1, ST_NO_DATA,  11'd7},
      '{OP_READ,        8'h00, 7'd8,   1'b1, 1'b1, ST_NO_DATA,  11'd7},
      '{OP_READ,        8'h00, 7'd7,   1'b0, 1'b0, ST_OK,       11'd0},
      '{OP_WRITE,       8'h80, 7'd127, 1'b0, 1'b1, ST_NO_SPACE, 11'd0},
      '{OP_WRITE,       8'h01, 7'd42,  1'b0, 1'b1, ST_NO_SPACE, 11'd0},
      '{OP_WRITE,       8'h7F, 7'd0,   1'b1, 1'b1, ST_NO_SPACE, 11'd0},
      '{OP_DISCARD,     8'hFF, 7'd0,   1'b1, 1'b1, ST_OK,       11'd0},
      '{FUNC_UNUSED_HI, 8'h00, 7'd0,   1'b0, 1'b1, ST_OK,       11'd0},
      '{OP_WRITE,       8'hC3, 7'd1,   1'b1, 1'b1, ST_OK,       11'd1}
   };

   logic clock;
   logic reset;

   brb_req_if req_ch ();
   brb_rsp_if rsp_ch ();

   byte_ring_buffer #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [BYTE_W-1:0]  mirror [DEPTH];
   logic [FILL_W-1:0]  rd_ptr = '0;
   logic [FILL_W-1:0]  wr_ptr = '0;
   logic [COUNT_W-1:0] open_len = '0;
   logic [COUNT_W-1:0] open_off = '0;
   bit                 burst_open = 1'b0;
   bit                 burst_dropping = 1'b0;
   rsp_beat_type       expected_beats [$];

   int errors = 0;
   int idle_cycles = 0;
   int sent_items = 0;
   bit hold_request = 1'b0;
   bit quiet = 1'b0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int stored_bytes();
      logic [FILL_W-1:0] diff;
      diff = wr_ptr - rd_ptr;
      return int'(diff);
   endfunction

   function automatic void expect_beat(logic [BYTE_W-1:0] value, logic [STATUS_W-1:0] st,
                                       bit last);
      int           fill;
      rsp_beat_type beat;
      fill            = stored_bytes();
      beat.out_byte   = value;
      beat.status     = st;
      beat.fill_count = fill[FILL_W-1:0];
      beat.is_empty   = (fill == 0);
      beat.is_full    = (fill == DEPTH);
      beat.last       = last;
      expected_beats.push_back(beat);
   endfunction

   function automatic void predict_request(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data,
                                           logic [COUNT_W-1:0] count, logic closing);
      int            fill;
      int            cnt;
      logic [AW-1:0] start;
      fill  = stored_bytes();
      cnt   = int'(count);
      start = rd_ptr[AW-1:0];
      case (func)
         OP_WRITE: begin
            if (!burst_open && !burst_dropping && cnt == 0) begin
               expect_beat('0, ST_OK, 1'b1);
            end else if (!burst_open && !burst_dropping &&
                         (cnt > MAX_BURST || cnt > DEPTH - fill)) begin
               burst_dropping = !closing;
               expect_beat('0, ST_NO_SPACE, 1'b1);
            end else if (burst_dropping) begin
               if (closing) burst_dropping = 1'b0;
               expect_beat('0, ST_NO_SPACE, 1'b1);
            end else begin
               if (!burst_open) begin
                  burst_open = 1'b1;
                  open_len   = count;
                  open_off   = '0;
               end
               if (open_off < open_len) begin
                  mirror[wr_ptr[AW-1:0] + AW'(open_off)] = data;
                  open_off = open_off + 1'b1;
               end
               if (closing) begin
                  wr_ptr     = wr_ptr + FILL_W'(open_off);
                  burst_open = 1'b0;
                  open_off   = '0;
                  open_len   = '0;
               end
               expect_beat('0, ST_OK, 1'b1);
            end
         end
         OP_READ, OP_PEEK: begin
            if (cnt == 0) begin
               expect_beat('0, ST_OK, 1'b1);
            end else if (cnt > MAX_BURST || cnt > fill) begin
               expect_beat('0, ST_NO_DATA, 1'b1);
            end else begin
               if (func == OP_READ) rd_ptr = rd_ptr + FILL_W'(count);
               for (int i = 0; i < cnt; i++)
                  expect_beat(mirror[start + AW'(i)], ST_OK, i == cnt - 1);
            end
         end
         OP_DISCARD: begin
            if (cnt > MAX_BURST || cnt > fill) begin
               expect_beat('0, ST_NO_DATA, 1'b1);
            end else begin
               rd_ptr = rd_ptr + FILL_W'(count);
               expect_beat('0, ST_OK, 1'b1);
            end
         end
         default: expect_beat('0, ST_OK, 1'b1);
      endcase
   endfunction

   function automatic void check_field(string name, logic [FILL_W-1:0] want,
                                       logic [FILL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic send(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data,
                       logic [COUNT_W-1:0] count, logic closing);
      int gap;
      int roll;
      gap = 0;
      if (!quiet) begin
         roll = $urandom_range(0, 99);
         if (roll >= 90) gap = $urandom_range(5, 20);
         else if (roll >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= func;
      req_ch.data_byte <= data;
      req_ch.count     <= count;
      req_ch.burst_end <= closing;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
      predict_request(func, data, count, closing);
   endtask

   task automatic random_status();
      send(FUNC_W'($urandom_range(int'(OP_STATUS), int'(FUNC_UNUSED_HI))),
           BYTE_W'($urandom_range(0, 255)), COUNT_W'($urandom_range(0, 127)),
           1'($urandom_range(0, 1)));
   endtask

   task automatic random_fetch();
      int                fill;
      int                cnt;
      int                roll;
      logic [FUNC_W-1:0] func;
      fill = stored_bytes();
      roll = $urandom_range(0, 3);
      func = (roll < 2) ? OP_READ : (roll == 2) ? OP_PEEK : OP_DISCARD;
      roll = $urandom_range(0, 9);
      if (roll < 7) cnt = (fill == 0) ? 1 : $urandom_range(1, (fill < 64) ? fill : 64);
      else if (roll == 7) cnt = 0;
      else if (roll == 8) cnt = (fill < 127) ? $urandom_range(fill + 1, 127)
                                             : $urandom_range(65, 127);
      else cnt = $urandom_range(0, 127);
      send(func, BYTE_W'($urandom_range(0, 255)), COUNT_W'(cnt), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_burst();
      int space;
      int len;
      int beats;
      int roll;
      space = DEPTH - stored_bytes();
      roll  = $urandom_range(0, 9);
      if (roll < 6) len = $urandom_range(1, 12);
      else if (roll < 8) len = (space >= 1 && space <= 64) ? space : $urandom_range(1, 64);
      else if (roll == 8) len = $urandom_range(65, 127);
      else len = $urandom_range(1, 4);
      beats = len;
      roll  = $urandom_range(0, 19);
      if (roll < 3) beats = $urandom_range(1, len);
      else if (roll < 5) beats = len + $urandom_range(1, 3);
      if (beats > 16) beats = $urandom_range(1, 6);
      for (int k = 0; k < beats; k++) begin
         if (k > 0 && $urandom_range(0, 99) < 6) begin
            if ($urandom_range(0, 1) == 1) random_fetch();
            else random_status();
         end
         send(OP_WRITE, BYTE_W'($urandom_range(0, 255)),
              (k == 0) ? COUNT_W'(len) : COUNT_W'($urandom_range(0, 127)), k == beats - 1);
      end
   endtask

   initial begin
      int           roll;
      int           write_share;
      bit           pressed;
      rsp_beat_type typed_beat;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= OP_STATUS;
      req_ch.data_byte <= '0;
      req_ch.count     <= '0;
      req_ch.burst_end <= 1'b0;
      reset            <= 1'b1;
      pressed          = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(script); i++) begin
         send(script[i].func, script[i].data_byte, script[i].count, script[i].burst_end);
         if (script[i].typed) begin
            typed_beat.out_byte   = '0;
            typed_beat.status     = script[i].status;
            typed_beat.fill_count = script[i].fill_count;
            typed_beat.is_empty   = (script[i].fill_count == '0);
            typed_beat.is_full    = (script[i].fill_count == FILL_W'(DEPTH));
            typed_beat.last       = 1'b1;
            expected_beats[expected_beats.size() - 1] = typed_beat;
         end
      end

      // Writes dominate until the long receiver stall, reads dominate after it.
      while (sent_items < ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         if (!pressed && sent_items >= ITEMS / 2) begin
            pressed      = 1'b1;
            hold_request = 1'b1;
         end
         write_share = pressed ? 22 : 72;
         roll = $urandom_range(0, 99);
         if (roll < write_share) random_burst();
         else if (roll < 94) random_fetch();
         else if (roll < 97) random_status();
         else send(OP_WRITE, BYTE_W'($urandom_range(0, 255)), COUNT_W'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)));
      end

      req_ch.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) $display("byte_ring_buffer_tb OK");
      else $display("byte_ring_buffer_tb NOT OK");
      $finish;
   end

   initial begin
      int gap_left;
      int hold_left;
      int window;
      int roll;
      bit calm;
      rsp_ch.ready <= 1'b0;
      gap_left  = 0;
      hold_left = 0;
      window    = 0;
      calm      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (window == 0) begin
            window = 100;
            calm   = ($urandom_range(0, 2) == 0);
         end
         window--;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 15) begin
               roll = $urandom_range(0, 99);
               if (roll < 70) gap_left = $urandom_range(1, 2);
               else if (roll < 95) gap_left = $urandom_range(3, 6);
               else gap_left = $urandom_range(10, 30);
            end
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_beats.size() == 0) begin
            $error("response beat arrived with nothing expected");
            errors++;
         end else begin
            want = expected_beats.pop_front();
            check_field("out_byte", FILL_W'(want.out_byte), FILL_W'(rsp_ch.out_byte));
            check_field("status", FILL_W'(want.status), FILL_W'(rsp_ch.status));
            check_field("fill_count", want.fill_count, rsp_ch.fill_count);
            check_field("is_empty", FILL_W'(want.is_empty), FILL_W'(rsp_ch.is_empty));
            check_field("is_full", FILL_W'(want.is_full), FILL_W'(rsp_ch.is_full));
            check_field("last", FILL_W'(want.last), FILL_W'(rsp_ch.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("byte_ring_buffer_tb NOT OK");
         $finish;
      end
   end

endmodule
